[design/ple_pkg.sv]
// ----------------------------------------------------------------------------
// ple_pkg
// types, codes and widths shared by the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int DATA_W       = 32;
   localparam int REQ_W        = 3;
   localparam int POS_W        = 7;
   localparam int LEN_W        = 7;
   localparam int STAT_W       = 2;
   localparam int CAPACITY_DEF = 64;
   localparam int MAX_CAPACITY = 4096;
   localparam int CNT_W        = $clog2(MAX_CAPACITY + 1);
   localparam int QUEUE_DEPTH  = 2;

   // request codes
   localparam logic [REQ_W-1:0] REQ_READ     = 3'd0;
   localparam logic [REQ_W-1:0] REQ_INS_HEAD = 3'd1;
   localparam logic [REQ_W-1:0] REQ_APPEND   = 3'd2;
   localparam logic [REQ_W-1:0] REQ_INS_POS  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_DELETE   = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

   localparam logic [DATA_W-1:0] BAD_READ_VALUE = '1;

   typedef struct packed {
      logic [REQ_W-1:0]         req_type;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] new_value;
   } req_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [STAT_W-1:0]        status;
      logic [LEN_W-1:0]         length;
   } rsp_item_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_READ,
      OP_INSERT,
      OP_DELETE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [CNT_W-1:0]    pos;
      logic [CNT_W-1:0]    old_cnt;
      logic [DATA_W-1:0]   value;
      logic [STAT_W-1:0]   status;
      logic [LEN_W-1:0]    length;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_push_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_WAIT,
      BK_MOVE,
      BK_FILL
   } bk_state_type;

endpackage

[design/ple_ram.sv]
// ----------------------------------------------------------------------------
// ple_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[design/ple_front.sv]
// ----------------------------------------------------------------------------
// ple_front
// accepts requests, checks position and fill, keeps the list length
// ----------------------------------------------------------------------------
module ple_front #(
   parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  ple_pkg::req_item_type req_item,
   input  ple_pkg::q_status_type q_stat,
   output logic                  busy,
   output ple_pkg::q_push_type   q_push
);
   import ple_pkg::*;

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   logic [CW-1:0]   count_ff, count_in;
   logic [CMPW-1:0] pos_c, cnt_c;
   logic            full, accept;
   cmd_type         cmd;

   assign busy   = q_stat.full;
   assign accept = start && !busy;
   assign pos_c  = CMPW'(req_item.position);
   assign cnt_c  = CMPW'(count_ff);
   assign full   = (count_ff == CW'(CAPACITY));

   always_comb begin
      cmd.op      = OP_NONE;
      cmd.pos     = CNT_W'(req_item.position);
      cmd.old_cnt = CNT_W'(count_ff);
      cmd.value   = '0;
      cmd.status  = ST_DONE;
      count_in    = count_ff;
      case (req_item.req_type)
         REQ_READ: begin
            if (pos_c < cnt_c) begin
               cmd.op = OP_READ;
            end else begin
               cmd.value  = BAD_READ_VALUE;
               cmd.status = ST_INVALID;
            end
         end
         REQ_INS_HEAD, REQ_APPEND, REQ_INS_POS: begin
            if (req_item.req_type == REQ_INS_HEAD) begin
               cmd.pos = '0;
            end else if (req_item.req_type == REQ_APPEND) begin
               cmd.pos = CNT_W'(count_ff);
            end
            if (req_item.req_type == REQ_INS_POS && pos_c > cnt_c) begin
               cmd.status = ST_INVALID;
            end else if (full) begin
               cmd.status = ST_FULL;
            end else begin
               cmd.op    = OP_INSERT;
               cmd.value = req_item.new_value;
               count_in  = count_ff + CW'(1);
            end
         end
         REQ_DELETE: begin
            if (pos_c < cnt_c) begin
               cmd.op   = OP_DELETE;
               count_in = count_ff - CW'(1);
            end else begin
               cmd.status = ST_INVALID;
            end
         end
         default: begin
            cmd.status = ST_INVALID;
         end
      endcase
      cmd.length = LEN_W'(count_in);
   end

   assign q_push.valid = accept;
   assign q_push.cmd   = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("list length above capacity");

   a_full_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd.status == ST_FULL) |=> $stable(count_ff))
      else $error("rejected insert changed the length");

endmodule

[design/ple_queue.sv]
// ----------------------------------------------------------------------------
// ple_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module ple_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  ple_pkg::q_push_type   q_push,
   input  logic                  q_pop,
   output ple_pkg::q_status_type q_stat,
   output ple_pkg::cmd_type      q_head
);
   import ple_pkg::*;

   localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   cmd_type        entry_ff [QUEUE_DEPTH];
   logic [QPW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCW-1:0] fill_ff;

   function automatic logic [QPW-1:0] ptr_next(input logic [QPW-1:0] p);
      logic [QPW-1:0] r;
      r = (p == QPW'(QUEUE_DEPTH - 1)) ? '0 : p + QPW'(1);
      return r;
   endfunction

   assign q_stat.empty = (fill_ff == '0);
   assign q_stat.full  = (fill_ff == QCW'(QUEUE_DEPTH));
   assign q_head       = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (q_push.valid) begin
         entry_ff[wr_ptr_ff] <= q_push.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (q_push.valid) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (q_pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         if (q_push.valid && !q_pop) begin
            fill_ff <= fill_ff + QCW'(1);
         end else if (q_pop && !q_push.valid) begin
            fill_ff <= fill_ff - QCW'(1);
         end
      end
   end

endmodule

[design/ple_back.sv]
// ----------------------------------------------------------------------------
// ple_back
// executes list commands on the entry ram and issues the responses
// ----------------------------------------------------------------------------
module ple_back #(
   parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ple_pkg::q_status_type q_stat,
   input  ple_pkg::cmd_type      q_head,
   output logic                  q_pop,
   output logic                  rsp_strobe,
   output ple_pkg::rsp_item_type rsp_item
);
   import ple_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   bk_state_type      state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [AW-1:0]     dest_ff, dest_in, end_ff, end_in, next_dest;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_ff, rsp_in;
   logic              ram_we;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [DATA_W-1:0] ram_wdata, ram_rdata;
   logic              ins_direct, del_direct, last_move, is_insert;

   // no entries to move when inserting at the end or deleting the last one
   assign ins_direct = (q_head.pos == q_head.old_cnt);
   assign del_direct = ((q_head.pos + CNT_W'(1)) == q_head.old_cnt);
   assign last_move  = (dest_ff == end_ff);
   assign is_insert  = (cmd_ff.op == OP_INSERT);
   assign next_dest  = is_insert ? dest_ff - AW'(1) : dest_ff + AW'(1);

   ple_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_entries (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               case (q_head.op)
                  OP_READ:   state_in = BK_WAIT;
                  OP_INSERT: state_in = ins_direct ? BK_FILL : BK_MOVE;
                  OP_DELETE: state_in = del_direct ? BK_IDLE : BK_MOVE;
                  default:   state_in = BK_IDLE;
               endcase
            end
         end
         BK_WAIT: state_in = BK_IDLE;
         BK_MOVE: begin
            if (last_move) begin
               state_in = is_insert ? BK_FILL : BK_IDLE;
            end
         end
         BK_FILL: state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      q_pop             = 1'b0;
      cmd_in            = cmd_ff;
      dest_in           = dest_ff;
      end_in            = end_ff;
      ram_we            = 1'b0;
      ram_waddr         = dest_ff;
      ram_wdata         = ram_rdata;
      ram_raddr         = '0;
      rsp_valid_in      = 1'b0;
      rsp_in.read_value = '0;
      rsp_in.status     = cmd_ff.status;
      rsp_in.length     = cmd_ff.length;
      case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               q_pop         = 1'b1;
               cmd_in        = q_head;
               rsp_in.status = q_head.status;
               rsp_in.length = q_head.length;
               case (q_head.op)
                  OP_READ: begin
                     ram_raddr = q_head.pos[AW-1:0];
                  end
                  OP_INSERT: begin
                     // shift from the tail down toward the insert point
                     dest_in   = q_head.old_cnt[AW-1:0];
                     end_in    = q_head.pos[AW-1:0] + AW'(1);
                     ram_raddr = q_head.old_cnt[AW-1:0] - AW'(1);
                  end
                  OP_DELETE: begin
                     if (del_direct) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        dest_in   = q_head.pos[AW-1:0];
                        end_in    = q_head.old_cnt[AW-1:0] - AW'(2);
                        ram_raddr = q_head.pos[AW-1:0] + AW'(1);
                     end
                  end
                  default: begin
                     rsp_valid_in      = 1'b1;
                     rsp_in.read_value = q_head.value;
                  end
               endcase
            end
         end
         BK_WAIT: begin
            rsp_valid_in      = 1'b1;
            rsp_in.read_value = ram_rdata;
         end
         BK_MOVE: begin
            ram_we = 1'b1;
            if (last_move) begin
               rsp_valid_in = !is_insert;
            end else begin
               dest_in   = next_dest;
               ram_raddr = is_insert ? next_dest - AW'(1) : next_dest + AW'(1);
            end
         end
         BK_FILL: begin
            ram_we       = 1'b1;
            ram_waddr    = cmd_ff.pos[AW-1:0];
            ram_wdata    = cmd_ff.value;
            rsp_valid_in = 1'b1;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      dest_ff <= dest_in;
      end_ff  <= end_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == BK_MOVE || state_ff == BK_FILL))
      else $error("entry write outside move or fill");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == BK_IDLE))
      else $error("command taken while busy");

   a_read_reply: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_WAIT) |=> rsp_valid_ff)
      else $error("read finished without a response");

endmodule

[design/positional_list_engine.sv]
// ----------------------------------------------------------------------------
// positional_list_engine
// ordered list of signed 32-bit values with read, insert and delete by position
// ----------------------------------------------------------------------------
// order: a rejected request or a delete of the last entry is answered when the
//   back end takes it from the queue, a read after the registered ram read,
//   a delete after its last entry move, an insert after any moves and the
//   write of the new value; the back end takes a new request only once it is
//   through with the last; entries move one per cycle through the single write
//   port of the entry ram; busy rises when the 2-deep queue is full
// the receiver cannot stall: each response shows for exactly one cycle
// reset clears the length, the queue and the sequencer; the entry ram is not
//   cleared, entries are read only after they were written
// ----------------------------------------------------------------------------
module positional_list_engine #(
   parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  ple_pkg::req_item_type req_item,
   // response channel
   output logic                  rsp_strobe,
   output ple_pkg::rsp_item_type rsp_item
);
   import ple_pkg::*;

   // front to queue
   q_push_type   q_push;
   // queue to back
   q_status_type q_stat;
   cmd_type      q_head;
   logic         q_pop;

   // front: checks each request against the current length, so status and
   // the new length are settled here, ahead of the entry moves
   ple_front #(
      .CAPACITY (CAPACITY)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .q_stat   (q_stat),
      .busy     (busy),
      .q_push   (q_push)
   );

   // command queue, keeps request order
   ple_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_pop  (q_pop),
      .q_stat (q_stat),
      .q_head (q_head)
   );

   // back: reads and shifts entries in the ram, one entry per cycle
   ple_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
